>>> design/length_prefix_deframer_queue_macros.svh
// Assertion macros for the length-prefix deframer queue checker.
// No dependencies; expects clk_i and rst_ni to be in scope where used.
`ifndef LENGTH_PREFIX_DEFRAMER_QUEUE_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_QUEUE_MACROS_SVH

// Property checked on every clock edge outside reset
`define LPDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define LPDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/lpdq_pkg.sv
// Shared constants and command codes for the length-prefix deframer queue.
// No dependencies.
package lpdq_pkg;

  // Ring geometry and header size
  localparam int SLOTS         = 8;
  localparam int SLOT_BYTES    = 4096;
  localparam int HEADER_DIGITS = 4;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 14;

  // Derived widths
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int HDR_W  = $clog2(HEADER_DIGITS + 1);
  localparam int PROD_W = LEN_W + 4;

  // Header arithmetic
  localparam logic [PROD_W-1:0] VALUE_CAP    = PROD_W'(16383);
  localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE   = 8'h39;
  // Slot capacity, one bit wider than a length so 16384 still fits
  localparam logic [LEN_W:0]    SLOT_BYTES_X = (LEN_W + 1)'(SLOT_BYTES);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LINK    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

endpackage

>>> design/length_prefix_deframer_queue.sv
// Length-prefix deframer with a ring of message slots, one item per cycle unless the result side stalls.
// Depends on lpdq_pkg.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid_i / in_ready_o, cmd_i, link_byte_i | one command: link byte, read or release
//  out     | out_valid_o / out_ready_i, seven result ports | one result per command
//
// One command a cycle sustained while results are taken; a taken beat passes through the
// input register, then the result register beside the registered message store read.
// Reset clears all control state at once; the message store and length table need
// no clearing pass, as only entries written by a committed frame are ever read.
// A stalled result register holds the input register, which then stalls the input.
module length_prefix_deframer_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lpdq_pkg::CMD_W-1:0]      cmd_i,
  input  logic [lpdq_pkg::BYTE_W-1:0]     link_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            accepted_o,
  output logic [lpdq_pkg::BYTE_W-1:0]     read_byte_o,
  output logic                            read_valid_o,
  output logic                            last_of_message_o,
  output logic [lpdq_pkg::LEN_W-1:0]      message_length_o,
  output logic                            queue_empty_o,
  output logic                            length_too_long_o
);
  import lpdq_pkg::*;

  // Input register
  logic              a_valid_q;
  logic [CMD_W-1:0]  a_cmd_q;
  logic [BYTE_W-1:0] a_byte_q;
  logic              a_fire;

  // Deframer and ring state
  logic [HDR_W-1:0]  hdr_seen_q, hdr_seen_d;
  logic [LEN_W-1:0]  hdr_value_q, hdr_value_d;
  logic              hdr_stopped_q, hdr_stopped_d;
  logic [LEN_W-1:0]  remaining_q, remaining_d;
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic [LEN_W-1:0]  wr_pos_q, wr_pos_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [LEN_W-1:0]  rd_pos_q, rd_pos_d;

  // Storage
  logic [BYTE_W-1:0] msg_mem [SLOTS][SLOT_BYTES];
  logic [LEN_W-1:0]  len_table_q [SLOTS];
  logic [BYTE_W-1:0] rd_data_q;

  // Result register
  logic              out_valid_q;
  logic              res_accepted_q, res_accepted_d;
  logic              res_rvalid_q, res_rvalid_d;
  logic              res_last_q, res_last_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic              res_empty_q, res_empty_d;
  logic              res_too_long_q, res_too_long_d;

  // Combinational helpers
  logic [SLOT_W-1:0] wr_slot_nxt, rd_slot_nxt;
  logic              ring_full, ring_empty, is_digit;
  logic [3:0]        digit;
  logic [BYTE_W-1:0] digit_full;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  hv, wp, rem, cur_len, rd_pos_inc;
  logic [HDR_W-1:0]  seen_inc;
  logic              mem_we, rd_en, len_we;
  logic [LEN_W-1:0]  len_wdata;

  // Handshake: the input register moves on when the result register is free
  assign a_fire     = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_cmd_q  <= cmd_i;
      a_byte_q <= link_byte_i;
    end
  end

  // Ring pointers and header digit arithmetic
  assign wr_slot_nxt = (wr_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : wr_slot_q + 1'b1;
  assign rd_slot_nxt = (rd_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : rd_slot_q + 1'b1;
  assign ring_full   = (wr_slot_nxt == rd_slot_q);
  assign ring_empty  = (rd_slot_q == wr_slot_q);
  assign is_digit    = (a_byte_q >= ASCII_ZERO) && (a_byte_q <= ASCII_NINE);
  assign digit_full  = a_byte_q - ASCII_ZERO;
  assign digit       = digit_full[3:0];
  // value * 10 + digit as shifts and adds
  assign prod        = PROD_W'({hdr_value_q, 3'b000}) + PROD_W'({hdr_value_q, 1'b0}) +
                       PROD_W'(digit);
  assign seen_inc    = hdr_seen_q + 1'b1;
  assign cur_len     = len_table_q[rd_slot_q];
  assign rd_pos_inc  = rd_pos_q + 1'b1;

  // Per-command work
  always_comb begin
    hdr_seen_d     = hdr_seen_q;
    hdr_value_d    = hdr_value_q;
    hdr_stopped_d  = hdr_stopped_q;
    remaining_d    = remaining_q;
    wr_slot_d      = wr_slot_q;
    wr_pos_d       = wr_pos_q;
    rd_slot_d      = rd_slot_q;
    rd_pos_d       = rd_pos_q;
    res_accepted_d = 1'b0;
    res_rvalid_d   = 1'b0;
    res_last_d     = 1'b0;
    res_len_d      = '0;
    res_empty_d    = 1'b0;
    res_too_long_d = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    len_we         = 1'b0;
    len_wdata      = '0;
    hv             = hdr_value_q;
    wp             = wr_pos_q;
    rem            = remaining_q;

    unique case (a_cmd_q)
      CMD_LINK: begin
        if (!ring_full) begin
          res_accepted_d = 1'b1;
          if (hdr_seen_q < HDR_W'(HEADER_DIGITS)) begin
            // header byte: digits accumulate until the first non-digit
            if (!hdr_stopped_q && is_digit) begin
              hv = (prod > VALUE_CAP) ? VALUE_CAP[LEN_W-1:0] : prod[LEN_W-1:0];
            end else begin
              hdr_stopped_d = 1'b1;
            end
            hdr_value_d = hv;
            hdr_seen_d  = seen_inc;
            if (seen_inc == HDR_W'(HEADER_DIGITS)) begin
              res_too_long_d = ({1'b0, hv} > SLOT_BYTES_X);
              remaining_d    = hv;
              wr_pos_d       = '0;
              if (hv == '0) begin
                // empty frame commits at once
                len_we        = 1'b1;
                len_wdata     = '0;
                wr_slot_d     = wr_slot_nxt;
                hdr_seen_d    = '0;
                hdr_value_d   = '0;
                hdr_stopped_d = 1'b0;
                remaining_d   = '0;
              end
            end
          end else begin
            // payload byte: bytes beyond slot capacity are dropped
            if ({1'b0, wr_pos_q} < SLOT_BYTES_X) begin
              mem_we = 1'b1;
              wp     = wr_pos_q + 1'b1;
            end
            if (remaining_q != '0) begin
              rem = remaining_q - 1'b1;
            end
            wr_pos_d    = wp;
            remaining_d = rem;
            if (rem == '0) begin
              len_we        = 1'b1;
              len_wdata     = wp;
              wr_slot_d     = wr_slot_nxt;
              wr_pos_d      = '0;
              hdr_seen_d    = '0;
              hdr_value_d   = '0;
              hdr_stopped_d = 1'b0;
            end
          end
        end
      end
      CMD_READ, CMD_RELEASE: begin
        if (ring_empty) begin
          res_empty_d = 1'b1;
        end else begin
          res_len_d = cur_len;
          if (a_cmd_q == CMD_RELEASE) begin
            res_last_d = 1'b1;
            rd_slot_d  = rd_slot_nxt;
            rd_pos_d   = '0;
          end else if (({1'b0, rd_pos_q} < {1'b0, cur_len}) &&
                       ({1'b0, rd_pos_q} < SLOT_BYTES_X)) begin
            rd_en        = 1'b1;
            res_rvalid_d = 1'b1;
            rd_pos_d     = rd_pos_inc;
            if (rd_pos_inc >= cur_len) begin
              res_last_d = 1'b1;
              rd_slot_d  = rd_slot_nxt;
              rd_pos_d   = '0;
            end
          end else begin
            // empty message: the read just frees it
            res_last_d = 1'b1;
            rd_slot_d  = rd_slot_nxt;
            rd_pos_d   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_seen_q    <= '0;
      hdr_value_q   <= '0;
      hdr_stopped_q <= 1'b0;
      remaining_q   <= '0;
      wr_slot_q     <= '0;
      wr_pos_q      <= '0;
      rd_slot_q     <= '0;
      rd_pos_q      <= '0;
    end else if (a_fire) begin
      hdr_seen_q    <= hdr_seen_d;
      hdr_value_q   <= hdr_value_d;
      hdr_stopped_q <= hdr_stopped_d;
      remaining_q   <= remaining_d;
      wr_slot_q     <= wr_slot_d;
      wr_pos_q      <= wr_pos_d;
      rd_slot_q     <= rd_slot_d;
      rd_pos_q      <= rd_pos_d;
    end
  end

  // Message store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (a_fire && mem_we) begin
      msg_mem[wr_slot_q][wr_pos_q[OFF_W-1:0]] <= a_byte_q;
    end
    if (a_fire && rd_en) begin
      rd_data_q <= msg_mem[rd_slot_q][rd_pos_q[OFF_W-1:0]];
    end
  end

  // Length table, written on frame commit
  always_ff @(posedge clk_i) begin
    if (a_fire && len_we) begin
      len_table_q[wr_slot_q] <= len_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      res_accepted_q <= res_accepted_d;
      res_rvalid_q   <= res_rvalid_d;
      res_last_q     <= res_last_d;
      res_len_q      <= res_len_d;
      res_empty_q    <= res_empty_d;
      res_too_long_q <= res_too_long_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = res_accepted_q;
  assign read_byte_o       = res_rvalid_q ? rd_data_q : '0;
  assign read_valid_o      = res_rvalid_q;
  assign last_of_message_o = res_last_q;
  assign message_length_o  = res_len_q;
  assign queue_empty_o     = res_empty_q;
  assign length_too_long_o = res_too_long_q;

endmodule

>>> design/lpdq_checker.sv
// Port-level checker for the length-prefix deframer queue, with its bind.
// Depends on lpdq_pkg and length_prefix_deframer_queue_macros.svh.
`include "length_prefix_deframer_queue_macros.svh"

module lpdq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [lpdq_pkg::CMD_W-1:0]      cmd_i,
  input logic [lpdq_pkg::BYTE_W-1:0]     link_byte_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            accepted_o,
  input logic [lpdq_pkg::BYTE_W-1:0]     read_byte_o,
  input logic                            read_valid_o,
  input logic                            last_of_message_o,
  input logic [lpdq_pkg::LEN_W-1:0]      message_length_o,
  input logic                            queue_empty_o,
  input logic                            length_too_long_o
);
  import lpdq_pkg::*;

  // A stalled result beat holds every field
  property p_out_hold;
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(accepted_o) && $stable(read_byte_o) && $stable(read_valid_o) &&
      $stable(last_of_message_o) && $stable(message_length_o) &&
      $stable(queue_empty_o) && $stable(length_too_long_o);
  endproperty

  // A waiting command beat holds its payload
  property p_in_hold;
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(cmd_i) && $stable(link_byte_i);
  endproperty

  // An empty-queue result carries nothing else
  property p_empty_alone;
    out_valid_o && queue_empty_o |->
      !accepted_o && !read_valid_o && !last_of_message_o && message_length_o == '0 &&
      !length_too_long_o;
  endproperty

  // A taken link byte yields no read-side result
  property p_link_only;
    out_valid_o && accepted_o |->
      !read_valid_o && !last_of_message_o && message_length_o == '0 && read_byte_o == '0 &&
      !queue_empty_o;
  endproperty

  `LPDQ_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")
  `LPDQ_ASSERT(a_in_hold, p_in_hold, "command beat changed while waiting")
  `LPDQ_ASSERT(a_empty_alone, p_empty_alone, "empty result carries other flags")
  `LPDQ_ASSERT(a_link_only, p_link_only, "link result carries read fields")
  `LPDQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind length_prefix_deframer_queue lpdq_checker u_lpdq_checker (.*);
